### rtl/core/lzbd_pkg.sv
// Shared types and constants for the LZ bitstream decompressor.
package lzbd_pkg;

  localparam int unsigned WindowDepthDefault = 65536;

  typedef enum logic [2:0] {
    ST_TAKEN = 3'd0,
    ST_BUSY  = 3'd1,
    ST_BYTE  = 3'd2,
    ST_NEED  = 3'd3,
    ST_DONE  = 3'd4,
    ST_ERROR = 3'd5
  } status_t;

  localparam logic [1:0] REG_MAX_PREFIX  = 2'd0;
  localparam logic [1:0] REG_LONG_OFFSET = 2'd1;
  localparam logic [1:0] REG_OUTPUT_SIZE = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [31:0] out_count;
  } out_item_t;

  // History memory request from the decoder.
  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic [23:0] wr_addr;
    logic [23:0] rd_addr;
    logic [7:0]  wr_data;
  } hist_req_t;

endpackage

### rtl/core/lz_bitstream_decompressor.sv
// Top level of the LZ bitstream decompressor.
// Input transactions either supply one compressed byte (mode 0) or pull one
// output byte (mode 1). Each input transaction yields exactly one result
// transaction carrying status, the byte and the running output count.
// Supplied bytes and done or error answers are ready in the cycle after the input
// transaction is accepted, and the next input can follow right away. A pull
// walks the bitstream at most one bit per cycle in the decoder, so a literal is
// out once its flag bit and data bits are read, and a copied byte after a copy step
// that reads the history memory and a read state that emits its data. Up to one
// transaction waits in the output register; further input is stalled until
// it is taken.
// The history memory holds WINDOW_DEPTH bytes and needs no clearing at reset.
// Reset (rst_n low, synchronous) restores the registers to their defaults
// and returns the decoder to expecting a flag bit.
// Registers must be written over the cfg_ APB port only while the block is idle
// (not enforced by the block): 0 max_prefix_bits, 1 long_offset_bits, 2 output_size.
module lz_bitstream_decompressor #(
  parameter int unsigned WINDOW_DEPTH = lzbd_pkg::WindowDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lzbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lzbd_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [7:0]  max_prefix_r;
  logic [7:0]  long_off_r;
  logic [31:0] out_size_r;
  logic [1:0]  reg_idx;
  lzbd_pkg::hist_req_t hreq;
  logic [7:0]  hdata;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_prefix_r <= 8'd0;
      long_off_r   <= 8'd8;
      out_size_r   <= 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_idx)
        lzbd_pkg::REG_MAX_PREFIX:  max_prefix_r <= cfg_pwdata[7:0];
        lzbd_pkg::REG_LONG_OFFSET: long_off_r   <= cfg_pwdata[7:0];
        lzbd_pkg::REG_OUTPUT_SIZE: out_size_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      lzbd_pkg::REG_MAX_PREFIX:  cfg_prdata = {24'd0, max_prefix_r};
      lzbd_pkg::REG_LONG_OFFSET: cfg_prdata = {24'd0, long_off_r};
      lzbd_pkg::REG_OUTPUT_SIZE: cfg_prdata = out_size_r;
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  lzbd_decoder #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dec (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .max_prefix_bits(max_prefix_r), .long_offset_bits(long_off_r),
    .output_size(out_size_r), .hreq, .hist_rd_data(hdata)
  );

  lzbd_history #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_hist (
    .clk, .req(hreq), .rd_data(hdata)
  );

endmodule

### rtl/core/lzbd_history.sv
// History memory: one write port and one registered read port.
module lzbd_history #(
  parameter int unsigned WINDOW_DEPTH = lzbd_pkg::WindowDepthDefault,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic              clk,
  input  lzbd_pkg::hist_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [WINDOW_DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

### rtl/core/lzbd_decoder.sv
// Bit-level token decoder: at most one bit per cycle, copies through the history memory.
module lzbd_decoder #(
  parameter int unsigned WINDOW_DEPTH = lzbd_pkg::WindowDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lzbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lzbd_pkg::out_item_t out_data,
  input  logic [7:0]          max_prefix_bits,
  input  logic [7:0]          long_offset_bits,
  input  logic [31:0]         output_size,
  output lzbd_pkg::hist_req_t hreq,
  input  logic [7:0]          hist_rd_data
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  typedef enum logic [2:0] {
    PH_FLAG, PH_PREFIX, PH_LITERAL, PH_LENGTH, PH_OFFSET, PH_COPY
  } phase_t;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_READ, S_OUT} ctl_t;

  ctl_t              ctl_r;
  phase_t            ph_r;
  logic              mode_r;
  logic [7:0]        pbits_r;
  logic [3:0]        pcnt_r;
  logic              ended_r;
  logic [7:0]        prefix_r;
  logic [31:0]       field_r;
  logic [5:0]        left_r;
  logic [33:0]       copy_r;
  logic [33:0]       back_r;
  logic [31:0]       produced_r;
  logic              err_r;
  lzbd_pkg::out_item_t out_r;
  logic              out_valid_r;

  logic        bit_v;
  logic [33:0] room;
  logic [33:0] copy_len;
  logic [33:0] back_sum;

  assign bit_v     = pbits_r[7];
  assign room      = {2'b0, output_size} - {2'b0, produced_r};
  assign copy_len  = ({2'b0, field_r} | (34'd1 << prefix_r[5:0])) + 34'd1;
  assign back_sum  = {2'b0, field_r} + copy_r;
  assign in_stall  = (ctl_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // History accesses: write on emit, read of the copy source.
  always_comb begin
    hreq         = '0;
    hreq.rd_addr = 24'(produced_r - back_r[31:0]);
    hreq.wr_addr = 24'(produced_r);
    if (ctl_r == S_RUN && ph_r == PH_COPY) hreq.rd_en = 1'b1;
    if (ctl_r == S_READ) begin
      hreq.wr_en   = 1'b1;
      hreq.wr_data = hist_rd_data;
    end else if (ctl_r == S_RUN && ph_r == PH_LITERAL && left_r == 6'd0) begin
      hreq.wr_en   = 1'b1;
      hreq.wr_data = field_r[7:0];
    end
  end

  // Control sequencer and decoding state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= S_IDLE;
      ph_r        <= PH_FLAG;
      pcnt_r      <= '0;
      pbits_r     <= '0;
      ended_r     <= 1'b0;
      prefix_r    <= '0;
      field_r     <= '0;
      left_r      <= '0;
      copy_r      <= '0;
      back_r      <= '0;
      produced_r  <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      unique case (ctl_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            mode_r <= in_data.mode;
            if (err_r) begin
              out_r <= '{status: lzbd_pkg::ST_ERROR, out_byte: 8'd0, out_count: produced_r};
              out_valid_r <= 1'b1;
            end else if (!in_data.mode) begin
              if (pcnt_r == 4'd0 && !ended_r) begin
                pbits_r <= in_data.in_byte;
                pcnt_r  <= 4'd8;
                ended_r <= in_data.in_last;
                out_r <= '{status: lzbd_pkg::ST_TAKEN, out_byte: 8'd0,
                           out_count: produced_r};
              end else begin
                out_r <= '{status: lzbd_pkg::ST_BUSY, out_byte: 8'd0,
                           out_count: produced_r};
              end
              out_valid_r <= 1'b1;
            end else if (produced_r >= output_size) begin
              out_r <= '{status: lzbd_pkg::ST_DONE, out_byte: 8'd0, out_count: produced_r};
              out_valid_r <= 1'b1;
            end else begin
              out_valid_r <= 1'b0;
              ctl_r <= S_RUN;
            end
          end else if (out_valid_r && !out_stall) begin
            // The receiver took the waiting result.
            out_valid_r <= 1'b0;
          end
        end
        S_RUN: begin
          // One decoding step per cycle.
          case (ph_r)
            PH_COPY: begin
              ctl_r <= S_READ;
            end
            PH_FLAG, PH_PREFIX, PH_LITERAL, PH_LENGTH, PH_OFFSET: begin
              if ((ph_r == PH_PREFIX && prefix_r >= max_prefix_bits) ||
                  ((ph_r == PH_LITERAL || ph_r == PH_LENGTH || ph_r == PH_OFFSET)
                   && left_r == 6'd0)) begin
                // Field complete, no bit consumed.
                if (ph_r == PH_PREFIX) begin
                  if (prefix_r == 8'd0) begin
                    copy_r <= 34'd2; left_r <= 6'd8; field_r <= '0; ph_r <= PH_OFFSET;
                  end else if (prefix_r > 8'd32) begin
                    err_r <= 1'b1; ctl_r <= S_OUT;
                  end else begin
                    field_r <= '0; left_r <= 6'(prefix_r); ph_r <= PH_LENGTH;
                  end
                end else if (ph_r == PH_LITERAL) begin
                  produced_r <= produced_r + 32'd1;
                  out_r <= '{status: lzbd_pkg::ST_BYTE, out_byte: field_r[7:0],
                             out_count: produced_r + 32'd1};
                  out_valid_r <= 1'b1;
                  ph_r  <= PH_FLAG;
                  ctl_r <= S_IDLE;
                end else if (ph_r == PH_LENGTH) begin
                  copy_r <= copy_len;
                  if (long_offset_bits > 8'd32) begin
                    err_r <= 1'b1; ctl_r <= S_OUT;
                  end else begin
                    left_r <= 6'(long_offset_bits); field_r <= '0; ph_r <= PH_OFFSET;
                  end
                end else begin
                  back_r <= back_sum;
                  if (back_sum > {2'b0, produced_r} || back_sum > 34'(WINDOW_DEPTH)) begin
                    err_r <= 1'b1; ctl_r <= S_OUT;
                  end else begin
                    if (copy_r > room) begin
                      copy_r <= room;
                      ph_r   <= (room == 34'd0) ? PH_FLAG : PH_COPY;
                    end else begin
                      ph_r <= (copy_r == 34'd0) ? PH_FLAG : PH_COPY;
                    end
                  end
                end
              end else if (pcnt_r == 4'd0) begin
                if (ended_r) err_r <= 1'b1;
                ctl_r <= S_OUT;
              end else begin
                pbits_r <= {pbits_r[6:0], 1'b0};
                pcnt_r  <= pcnt_r - 4'd1;
                case (ph_r)
                  PH_FLAG: begin
                    if (!bit_v) begin
                      field_r <= '0; left_r <= 6'd8; ph_r <= PH_LITERAL;
                    end else begin
                      prefix_r <= '0; ph_r <= PH_PREFIX;
                    end
                  end
                  PH_PREFIX: begin
                    if (bit_v) prefix_r <= prefix_r + 8'd1;
                    else if (prefix_r == 8'd0) begin
                      copy_r <= 34'd2; left_r <= 6'd8; field_r <= '0; ph_r <= PH_OFFSET;
                    end else if (prefix_r > 8'd32) begin
                      err_r <= 1'b1; ctl_r <= S_OUT;
                    end else begin
                      field_r <= '0; left_r <= 6'(prefix_r); ph_r <= PH_LENGTH;
                    end
                  end
                  default: begin
                    field_r <= {field_r[30:0], bit_v};
                    left_r  <= left_r - 6'd1;
                  end
                endcase
              end
            end
            default: ph_r <= PH_FLAG;
          endcase
        end
        S_READ: begin
          // Memory data is back: emit the copied byte.
          produced_r <= produced_r + 32'd1;
          out_r <= '{status: lzbd_pkg::ST_BYTE, out_byte: hist_rd_data,
                     out_count: produced_r + 32'd1};
          out_valid_r <= 1'b1;
          if (copy_r > 34'd0) begin
            copy_r <= copy_r - 34'd1;
            if (copy_r == 34'd1) ph_r <= PH_FLAG;
          end else begin
            ph_r <= PH_FLAG;
          end
          ctl_r <= S_IDLE;
        end
        S_OUT: begin
          // Stop status: error or need input.
          out_r <= '{status: err_r ? lzbd_pkg::ST_ERROR : lzbd_pkg::ST_NEED,
                     out_byte: 8'd0, out_count: produced_r};
          out_valid_r <= 1'b1;
          ctl_r <= S_IDLE;
        end
        default: ctl_r <= S_IDLE;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = mode_r ^ ^hreq.rd_addr[23:AW] ^ ^hreq.wr_addr[23:AW];

endmodule

### rtl/core/lzbd_checker.sv
// Port-level assertions for the LZ bitstream decompressor.
module lzbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lzbd_pkg::out_item_t out_data
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= lzbd_pkg::ST_ERROR)
    else $error("bad status");

  // Non-byte results carry a zero byte.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != lzbd_pkg::ST_BYTE |-> out_data.out_byte == 8'd0)
    else $error("byte not zero");

  // In the next cycle an accepted transaction is either answered or input is stalled.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall || out_valid)
    else $error("input taken without answer");

endmodule

bind lz_bitstream_decompressor lzbd_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
